// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/pbsq_pkg.sv =====
package pbsq_pkg;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd2;

    typedef struct packed {
        logic [15:0] divisor;
        logic gate_on;
        logic last_frame;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic last_out;
    } out_item_t;
endpackage

// ===== rtl/polyblep_square_tone_with_gate_ramp.sv =====
// a request runs through five serial divisions of 49 quotient bits each
// (one shared divider, one bit per cycle) and a shift-add multiply
// one request at a time: the next request is taken the cycle after the result
// register loads, a held result stalls the block
// reset: phase and gain cleared, registers to 44100 / 5 / 8000
`include "assert_macros.svh"
module polyblep_square_tone_with_gate_ramp import pbsq_pkg::*; #(
    parameter int TIMER_CLOCK_HZ = 1193182
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int DIVW = 49;

    typedef enum logic [2:0] {
        S_IDLE, S_FREQ, S_DT, S_SLEW, S_U1, S_U2, S_MUL, S_OUT
    } state_t;

    state_t state_reg;
    logic [17:0] sample_rate_reg;
    logic [6:0]  ramp_ms_reg;
    logic [14:0] amplitude_reg;
    logic [31:0] phase_reg;
    logic [16:0] gain_reg;
    in_item_t    item_reg;
    logic [31:0] dt_reg;
    logic        below_reg;
    logic        active_reg;
    logic signed [18:0] v_reg;
    logic [47:0] prod_reg;
    logic [5:0]  mcnt_reg;
    logic [35:0] mplr_reg;
    logic        neg_reg;
    logic        ovalid_reg;
    out_item_t   odata_reg;

    logic              dv_start;
    logic [DIVW-1:0]   dv_num, dv_den, dv_quo;
    logic              dv_done;
    pbsq_divider #(.NW(DIVW), .DW(DIVW), .QW(DIVW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
        .done(dv_done), .quo(dv_quo)
    );

    // blep distances
    logic [31:0] half_ph;
    logic        e1_lo, e1_hi, e2_lo, e2_hi;
    logic [32:0] one_m_dt;
    assign half_ph  = phase_reg + 32'h8000_0000;
    assign one_m_dt = 33'h1_0000_0000 - {1'b0, dt_reg};
    assign e1_lo = phase_reg < dt_reg;
    assign e1_hi = !e1_lo && ({1'b0, phase_reg} > one_m_dt);
    assign e2_lo = half_ph < dt_reg;
    assign e2_hi = !e2_lo && ({1'b0, half_ph} > one_m_dt);

    logic [31:0] x1, x2;
    assign x1 = e1_lo ? phase_reg : 32'(33'h1_0000_0000 - {1'b0, phase_reg});
    assign x2 = e2_lo ? half_ph : 32'(33'h1_0000_0000 - {1'b0, half_ph});

    // u in Q16 from the divider: floor(x*2^16/dt), x<dt; guard x>=dt
    function automatic logic signed [18:0] blep_f(input logic lo, input logic hi,
                                                  input logic [16:0] u);
        logic [33:0] sq;
        logic signed [19:0] r;
        sq = u * u;
        r = 20'sd0;
        if (lo)
            r = $signed({2'b0, u, 1'b0}) - $signed({2'b0, sq[33:16]}) - 20'sd65536;
        else if (hi)
            r = $signed({2'b0, sq[33:16]}) - $signed({2'b0, u, 1'b0}) + 20'sd65536;
        return r[18:0];
    endfunction

    logic [16:0] u_q;
    logic [20:0] freq_w;
    logic [16:0] slew_w, gain_next;
    logic [DIVW-1:0] slew_q;
    assign u_q    = dv_quo[16:0];
    assign slew_q = dv_quo;
    assign slew_w = (slew_q == '0) ? 17'd1 :
                    (slew_q > DIVW'(65536)) ? 17'd65536 : slew_q[16:0];
    logic [16:0] tgt;
    assign tgt = (item_reg.gate_on && below_reg) ? 17'd65536 : 17'd0;
    always_comb
    begin
        gain_next = gain_reg;
        if (gain_reg < tgt)
            gain_next = (tgt - gain_reg > slew_w) ? gain_reg + slew_w : tgt;
        else if (gain_reg > tgt)
            gain_next = (gain_reg - tgt > slew_w) ? gain_reg - slew_w : tgt;
    end

    logic [16:0] dsor;
    assign dsor = (in_data.divisor == 16'd0) ? 17'h10000 : {1'b0, in_data.divisor};
    assign freq_w = dv_quo[20:0];

    logic [24:0] srr;
    assign srr = sample_rate_reg * ramp_ms_reg;

    always_comb
    begin
        dv_start = 1'b0;
        dv_num = '0;
        dv_den = DIVW'(1);
        unique case (state_reg)
            S_IDLE:
            begin
                dv_start = in_valid;
                dv_num = DIVW'(TIMER_CLOCK_HZ);
                dv_den = DIVW'(dsor);
            end
            S_FREQ:
            begin
                dv_start = dv_done;
                dv_num = DIVW'(freq_w) << 32;
                dv_den = DIVW'(sample_rate_reg);
            end
            S_DT:
            begin
                dv_start = dv_done;
                dv_num = DIVW'(65536000);
                dv_den = (srr == 25'd0) ? DIVW'(1) : DIVW'(srr);
            end
            S_SLEW:
            begin
                dv_start = dv_done;
                dv_num = DIVW'(x1) << 16;
                dv_den = (dt_reg == 32'd0) ? DIVW'(1) : DIVW'(dt_reg);
            end
            S_U1:
            begin
                dv_start = dv_done;
                dv_num = DIVW'(x2) << 16;
                dv_den = (dt_reg == 32'd0) ? DIVW'(1) : DIVW'(dt_reg);
            end
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    logic [17:0] vmag;
    assign vmag = v_reg[18] ? 18'(-v_reg) : 18'(v_reg);

    logic [15:0] sat;
    logic [47:0] pr;
    assign pr = prod_reg >> 32;
    always_comb
    begin
        if (!active_reg)
            sat = 16'd0;
        else if (neg_reg)
            sat = (pr > 48'd32768) ? 16'h8000 : 16'(-pr[16:0]);
        else
            sat = (pr > 48'd32767) ? 16'h7FFF : pr[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sample_rate_reg <= 18'd44100;
            ramp_ms_reg     <= 7'd5;
            amplitude_reg   <= 15'd8000;
            phase_reg       <= '0;
            gain_reg        <= '0;
            ovalid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_SAMPLE_RATE: sample_rate_reg <= cfg_data;
                    REG_RAMP_MS:     ramp_ms_reg <= cfg_data[6:0];
                    REG_AMPLITUDE:   amplitude_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (state_reg == S_OUT && (!ovalid_reg || out_ready))
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        state_reg <= S_FREQ;
                    end
                S_FREQ:
                    if (dv_done)
                    begin
                        below_reg <= (sample_rate_reg != 18'd0) &&
                                     ({freq_w, 1'b0} < 22'(sample_rate_reg));
                        state_reg <= S_DT;
                    end
                S_DT:
                    if (dv_done)
                    begin
                        dt_reg    <= below_reg ? dv_quo[31:0] : 32'd0;
                        state_reg <= S_SLEW;
                    end
                S_SLEW:
                    if (dv_done)
                    begin
                        gain_reg  <= (srr == 25'd0) ? ((gain_reg != tgt) ? tgt : gain_reg)
                                                    : gain_next;
                        state_reg <= S_U1;
                    end
                S_U1:
                    if (dv_done)
                    begin
                        v_reg <= (phase_reg[31] ? -19'sd65536 : 19'sd65536) +
                                 blep_f(e1_lo, e1_hi, u_q);
                        active_reg <= (gain_reg != 17'd0) && below_reg && (dt_reg != 32'd0);
                        state_reg <= S_U2;
                    end
                S_U2:
                    if (dv_done)
                    begin
                        v_reg     <= v_reg - blep_f(e2_lo, e2_hi, u_q);
                        state_reg <= S_MUL;
                        mcnt_reg  <= 6'd32;
                        prod_reg  <= '0;
                        mplr_reg  <= 36'(gain_reg) * 36'(amplitude_reg) ;
                    end
                S_MUL:
                begin
                    // shift-add: one multiplier bit per cycle
                    if (mcnt_reg == 6'd32)
                        neg_reg <= v_reg[18];
                    if (mplr_reg[0])
                        prod_reg <= prod_reg + (48'(vmag) << (6'd32 - mcnt_reg));
                    mplr_reg <= mplr_reg >> 1;
                    mcnt_reg <= mcnt_reg - 6'd1;
                    if (mcnt_reg == 6'd1)
                    begin
                        state_reg <= S_OUT;
                        if (active_reg)
                            phase_reg <= phase_reg + dt_reg;
                    end
                end
                S_OUT:
                    if (!ovalid_reg || out_ready)
                    begin
                        odata_reg.left_sample  <= sat;
                        odata_reg.right_sample <= sat;
                        odata_reg.last_out     <= item_reg.last_frame;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMP(a_lr_equal, out_valid, out_data.left_sample == out_data.right_sample)
    `ASSERT_IMP(a_gain_range, 1'b1, gain_reg <= 17'd65536)
    `ASSERT_NXT(a_phase_hold, (state_reg != S_MUL) && !(in_valid && in_ready) &&
                state_reg == S_IDLE, $stable(phase_reg))
endmodule

// ===== rtl/pbsq_divider.sv =====
module pbsq_divider import pbsq_pkg::*; #(
    parameter int NW = 48,
    parameter int DW = 48,
    parameter int QW = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quo
);
    // restoring division, one quotient bit per cycle
    localparam int CW = $clog2(QW + 1);
    localparam int RW = DW + 1;
    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] n_reg;
    logic [RW-1:0] r_reg;
    logic [DW-1:0] d_reg;
    logic [QW-1:0] q_reg;
    logic [RW-1:0] sh;
    logic          ge;

    assign sh = {r_reg[RW-2:0], n_reg[NW-1]};
    assign ge = sh >= {1'b0, d_reg};
    assign quo = q_reg;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1)) && !start;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
                n_reg    <= num << (NW - QW);
                r_reg    <= '0;
                d_reg    <= den;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                n_reg   <= n_reg << 1;
                r_reg   <= ge ? sh - {1'b0, d_reg} : sh;
                q_reg   <= {q_reg[QW-2:0], ge};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end
endmodule
